>>> rtl/evh_pkg.sv
// constants, register codes and helpers for the energy voice activity detector
`timescale 1ns / 1ps

package evh_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int SQ_W          = 2 * SAMPLE_BITS - 1;
    localparam int THR_W         = 31;
    localparam int HANG_W        = 16;
    localparam int CNT32_W       = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 31;
    localparam int OUT_DATA_W    = 104;
    localparam int MAX_FRAME_LEN = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HANG      = 1'd1;

    localparam logic [THR_W-1:0]  THR_RESET  = 31'd107374;
    localparam logic [HANG_W-1:0] HANG_RESET = 16'd30;

    function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] v);
        sat_inc = (v == {CNT32_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

>>> rtl/energy_vad_hangover.sv
// energy voice activity detector with hangover, one sample per clock unless the output stalls
//
// input stream: one signed sample per transaction, tlast on the last sample
// of a frame. output stream: one result per frame, carrying the speech flag
// and the saturating frame counters (total, speech, silence).
// config port: write enable, register index (0 threshold, 1 hang frames)
// and data; write only while no frame is in flight.
// the datapath is a four stage pipe: input register, square, running
// energy-minus-threshold accumulation with the frame compare, and the hang
// counter plus result register. one sample is taken every cycle unless the output stalls.
// the frame-end sample passes stages a, b and c before stage d registers the result.
// the single multiply-accumulate takes one sample per cycle while the pipe is not stalled.
// reset clears the accumulator, the counters and the pipe, sets the hang
// counter to not active and the registers to their defaults.
// a stall on the output holds the pipe only when a finished frame result
// would have to enter a still occupied output register; ordinary samples
// keep flowing while an earlier result waits.
`timescale 1ns / 1ps

module energy_vad_hangover
    import evh_pkg::*;
#(
    parameter int MaxFrameLen = MAX_FRAME_LEN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] s_axis_tdata,  // sample
    input  logic                  s_axis_tlast,   // frame_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // is_speech, total_frames, active_frames, bypassed_frames, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(MaxFrameLen + 1);
    localparam int ACC_W = $clog2(MaxFrameLen) + 32;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MaxFrameLen);

    logic [THR_W-1:0]  r_thr;
    logic [HANG_W-1:0] r_hang;

    logic              en;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_a_vld, r_a_last, r_a_use;
    logic signed [SAMPLE_BITS-1:0] r_a_smp;

    logic              r_b_vld, r_b_last, r_b_use;
    logic [SQ_W-1:0]   r_b_sq;

    logic signed [ACC_W-1:0] r_diff, n_sum;
    logic              n_active;
    logic              r_c_judge, r_c_active;

    logic [HANG_W-1:0] r_since, n_since;
    logic              n_speech;
    logic              r_speech;
    logic [CNT32_W-1:0] r_total, r_act_cnt, r_byp_cnt;

    logic signed [2*SAMPLE_BITS-1:0] sq_full;

    assign en            = !r_c_judge || !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_hang <= HANG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD: r_thr  <= i_cfg_wdata[THR_W-1:0];
                REG_HANG:      r_hang <= i_cfg_wdata[HANG_W-1:0];
                default:       ;
            endcase
        end
    end

    // stage a: input register and frame length count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_cnt   <= '0;
        end else if (en) begin
            r_a_vld <= s_axis_tvalid;
            if (s_axis_tvalid) begin
                if (s_axis_tlast) begin
                    r_cnt <= '0;
                end else if (r_cnt < CNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_smp  <= s_axis_tdata;
            r_a_last <= s_axis_tlast;
            r_a_use  <= (r_cnt < CNT_MAX);
        end
    end

    // stage b: square
    assign sq_full = r_a_smp * r_a_smp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sq   <= sq_full[SQ_W-1:0];
            r_b_last <= r_a_last;
            r_b_use  <= r_a_use;
        end
    end

    // stage c: energy minus threshold per sample, frame compare
    always_comb begin
        n_sum = r_diff;
        if (r_b_use) begin
            n_sum = r_diff + $signed(ACC_W'(r_b_sq)) - $signed(ACC_W'(r_thr));
        end
        n_active = !n_sum[ACC_W-1] && (n_sum != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff    <= '0;
            r_c_judge <= 1'b0;
        end else if (en) begin
            r_c_judge <= r_b_vld && r_b_last;
            if (r_b_vld) begin
                r_diff <= r_b_last ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_active <= n_active;
        end
    end

    // stage d: hang counter, frame counters, output register
    always_comb begin
        n_since  = r_since;
        n_speech = 1'b1;
        if (r_c_active) begin
            n_since = '0;
        end else begin
            if (r_since != {HANG_W{1'b1}}) begin
                n_since = r_since + 1'b1;
            end
            n_speech = (n_since < r_hang);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since       <= {HANG_W{1'b1}};
            r_speech      <= 1'b0;
            r_total       <= '0;
            r_act_cnt     <= '0;
            r_byp_cnt     <= '0;
            m_axis_tvalid <= 1'b0;
        end else if (en && r_c_judge) begin
            r_since       <= n_since;
            r_speech      <= n_speech;
            r_total       <= sat_inc(r_total);
            if (n_speech) begin
                r_act_cnt <= sat_inc(r_act_cnt);
            end else begin
                r_byp_cnt <= sat_inc(r_byp_cnt);
            end
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    assign m_axis_tdata = {
        (OUT_DATA_W - 1 - 3 * CNT32_W)'(0),
        r_byp_cnt, r_act_cnt, r_total, r_speech
    };

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("frame sample count above limit");

    a_active_clears_hang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_c_judge && r_c_active) |=> (r_since == '0) && r_speech)
        else $error("active frame did not clear hang counter");

    a_one_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_c_judge && (r_act_cnt != {CNT32_W{1'b1}})
            && (r_byp_cnt != {CNT32_W{1'b1}}))
        |=> $countones({r_act_cnt != $past(r_act_cnt),
                        r_byp_cnt != $past(r_byp_cnt)}) == 1)
        else $error("frame counted as both or neither speech and silence");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_c_judge))
        else $error("result without a judged frame");

    a_counters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(en && r_c_judge) |=> $stable(r_total) && $stable(r_since))
        else $error("frame state changed without a judged frame");

endmodule
